// ===== src/pict_pkg.sv =====
// ----------------------------------------------------------------------------
// pict_pkg: shared types and constants of the circumcircle test
// Result codes, fixed-point constants and the arctangent table of the CORDIC.
// ----------------------------------------------------------------------------
package pict_pkg;

	// CORDIC datapath: x/y signed, z signed Q.30 radians
	localparam int CORDIC_STEPS = 31;
	localparam int CW           = 62;
	localparam int ZW           = 34;
	localparam int NORM_MSB     = 57;

	localparam longint PI_Q30      = 64'd3373259426;
	localparam longint HALF_PI_Q30 = 64'd1686629713;

	// tolerance register
	localparam int              TOL_W     = 13;
	localparam logic [TOL_W-1:0] TOL_RESET = 13'd82;

	localparam int SUM_OUT_W = 16;

	typedef enum logic [1:0] {
		POS_ON      = 2'd0,
		POS_INSIDE  = 2'd1,
		POS_OUTSIDE = 2'd2
	} pos_t;

	typedef struct packed {
		pos_t                  position;
		logic [SUM_OUT_W-1:0]  angle_sum;
		logic                  degenerate;
	} res_t;

	typedef struct packed {
		logic valid;
		logic degenerate;
	} side_t;

	// atan(2^-i) * 2^30, truncated; entries 27 to 30 are rounded up
	function automatic logic [31:0] atan_q30(input int unsigned i);
		logic [31:0] a;
		case (i)
			0:  a = 32'h3243F6A8;
			1:  a = 32'h1DAC6705;
			2:  a = 32'h0FADBAFC;
			3:  a = 32'h07F56EA6;
			4:  a = 32'h03FEAB76;
			5:  a = 32'h01FFD55B;
			6:  a = 32'h00FFFAAA;
			7:  a = 32'h007FFF55;
			8:  a = 32'h003FFFEA;
			9:  a = 32'h001FFFFD;
			10: a = 32'h000FFFFF;
			11: a = 32'h0007FFFF;
			12: a = 32'h0003FFFF;
			13: a = 32'h0001FFFF;
			14: a = 32'h0000FFFF;
			15: a = 32'h00007FFF;
			16: a = 32'h00003FFF;
			17: a = 32'h00001FFF;
			18: a = 32'h00000FFF;
			19: a = 32'h000007FF;
			20: a = 32'h000003FF;
			21: a = 32'h000001FF;
			22: a = 32'h000000FF;
			23: a = 32'h0000007F;
			24: a = 32'h0000003F;
			25: a = 32'h0000001F;
			26: a = 32'h0000000F;
			27: a = 32'h00000008;
			28: a = 32'h00000004;
			29: a = 32'h00000002;
			30: a = 32'h00000001;
			default: a = 32'h0;
		endcase
		return a;
	endfunction

endpackage

// ===== src/pict_pts_if.sv =====
// ----------------------------------------------------------------------------
// pict_pts_if: point-set channel
// Valid/ready channel carrying the four points A, B, C, D of one test.
// ----------------------------------------------------------------------------
interface pict_pts_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] a_x;
	logic signed [COORD_WIDTH-1:0] a_y;
	logic signed [COORD_WIDTH-1:0] b_x;
	logic signed [COORD_WIDTH-1:0] b_y;
	logic signed [COORD_WIDTH-1:0] c_x;
	logic signed [COORD_WIDTH-1:0] c_y;
	logic signed [COORD_WIDTH-1:0] d_x;
	logic signed [COORD_WIDTH-1:0] d_y;

	modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, input ready);
	modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, output ready);
endinterface

// ===== src/pict_res_if.sv =====
// ----------------------------------------------------------------------------
// pict_res_if: test result channel
// Valid/ready channel carrying position, angle sum and degenerate flag.
// ----------------------------------------------------------------------------
interface pict_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  position;
	logic [15:0] angle_sum;
	logic        degenerate;

	modport source (output valid, position, angle_sum, degenerate, input ready);
	modport sink   (input valid, position, angle_sum, degenerate, output ready);
endinterface

// ===== src/pict_front.sv =====
// ----------------------------------------------------------------------------
// pict_front: vector pair front end
// Narrows both side vectors, forms dot and cross products, folds the pair
// into the first quadrant and normalizes it for the CORDIC (stages s2..s8).
// ----------------------------------------------------------------------------
module pict_front #(
	parameter int DW = 17
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [DW-1:0]          ux,
	input  logic signed [DW-1:0]          uy,
	input  logic signed [DW-1:0]          vx,
	input  logic signed [DW-1:0]          vy,
	output logic signed [pict_pkg::CW-1:0] cx,
	output logic signed [pict_pkg::CW-1:0] cy,
	output logic signed [pict_pkg::ZW-1:0] cz
);
	localparam int NW  = (DW > 32) ? 32 : DW;
	localparam int PW  = 2 * NW + 1;
	localparam int GN  = (PW + 7) / 8;
	localparam int PBW = $clog2(GN * 8);
	localparam int WW  = PW + pict_pkg::NORM_MSB;

	function automatic logic fits(input logic signed [DW-1:0] v);
		logic signed [39:0] e;
		e = 40'(v);
		return (e > -40'sd2147483648) && (e < 40'sd2147483648);
	endfunction

	// s2: narrow each vector until both parts stay below 2^31
	logic signed [NW-1:0] nux, nuy, nvx, nvy;
	logic signed [NW-1:0] ux_s2, uy_s2, vx_s2, vy_s2;

	always_comb begin
		logic signed [DW-1:0] tx, ty;
		nux = NW'(ux);
		nuy = NW'(uy);
		nvx = NW'(vx);
		nvy = NW'(vy);
		for (int k = 3; k >= 0; k--) begin
			tx = ux >>> k;
			ty = uy >>> k;
			if (fits(tx) && fits(ty)) begin
				nux = NW'(tx);
				nuy = NW'(ty);
			end
			tx = vx >>> k;
			ty = vy >>> k;
			if (fits(tx) && fits(ty)) begin
				nvx = NW'(tx);
				nvy = NW'(ty);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s2 <= nux;
			uy_s2 <= nuy;
			vx_s2 <= nvx;
			vy_s2 <= nvy;
		end
	end

	// s3: four products
	logic signed [2*NW-1:0] pxx_s3, pyy_s3, pxy_s3, pyx_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s3 <= ux_s2 * vx_s2;
			pyy_s3 <= uy_s2 * vy_s2;
			pxy_s3 <= ux_s2 * vy_s2;
			pyx_s3 <= uy_s2 * vx_s2;
		end
	end

	// s4: dot and cross
	logic signed [PW-1:0] dot_s4, crs_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s4 <= PW'(pxx_s3) + PW'(pyy_s3);
			crs_s4 <= PW'(pxy_s3) - PW'(pyx_s3);
		end
	end

	// s5: fold into the first quadrant, a quarter turn preloaded on z
	logic [PW-1:0] px_s5, py_s5;
	logic          half_s5;
	logic [PW-1:0] acrs;

	assign acrs = crs_s4[PW-1] ? PW'(-crs_s4) : PW'(crs_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			if (dot_s4[PW-1]) begin
				px_s5   <= acrs;
				py_s5   <= PW'(-dot_s4);
				half_s5 <= 1'b1;
			end else begin
				px_s5   <= PW'(dot_s4);
				py_s5   <= acrs;
				half_s5 <= 1'b0;
			end
		end
	end

	// s6: leading one inside each byte group
	logic [GN*8-1:0] ow;
	logic [GN-1:0]   nz;
	logic [2:0]      lead [GN];
	logic [PW-1:0]   px_s6, py_s6;
	logic            half_s6;
	logic [GN-1:0]   nz_s6;
	logic [2:0]      lead_s6 [GN];

	assign ow = (GN*8)'(px_s5 | py_s5);

	always_comb begin
		for (int g = 0; g < GN; g++) begin
			nz[g]   = |ow[g*8 +: 8];
			lead[g] = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (ow[g*8 + b]) begin
					lead[g] = 3'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s6   <= px_s5;
			py_s6   <= py_s5;
			half_s6 <= half_s5;
			nz_s6   <= nz;
			for (int g = 0; g < GN; g++) begin
				lead_s6[g] <= lead[g];
			end
		end
	end

	// s7: highest nonzero group gives the leading-one position
	logic [PBW-1:0] pos;
	logic [PW-1:0]  px_s7, py_s7;
	logic           half_s7;
	logic [PBW-1:0] p_s7;

	always_comb begin
		pos = '0;
		for (int g = 0; g < GN; g++) begin
			if (nz_s6[g]) begin
				pos = PBW'(g * 8 + int'(lead_s6[g]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s7   <= px_s6;
			py_s7   <= py_s6;
			half_s7 <= half_s6;
			p_s7    <= pos;
		end
	end

	// s8: shift so that the leading one lands on bit NORM_MSB
	logic [WW-1:0] wx, wy;
	logic signed [pict_pkg::CW-1:0] x_s8, y_s8;
	logic signed [pict_pkg::ZW-1:0] z_s8;

	assign wx = {px_s7, pict_pkg::NORM_MSB'(0)} >> p_s7;
	assign wy = {py_s7, pict_pkg::NORM_MSB'(0)} >> p_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s8 <= pict_pkg::CW'(wx[pict_pkg::NORM_MSB:0]);
			y_s8 <= pict_pkg::CW'(wy[pict_pkg::NORM_MSB:0]);
			z_s8 <= half_s7 ? pict_pkg::ZW'(pict_pkg::HALF_PI_Q30) : '0;
		end
	end

	assign cx = x_s8;
	assign cy = y_s8;
	assign cz = z_s8;

endmodule

// ===== src/pict_cordic_step.sv =====
// ----------------------------------------------------------------------------
// pict_cordic_step: one vectoring CORDIC micro-rotation
// Rotates (x, y) toward the x axis by atan(2^-STEP) and tracks the angle.
// ----------------------------------------------------------------------------
module pict_cordic_step #(
	parameter int STEP = 0
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [pict_pkg::CW-1:0] x_prev,
	input  logic signed [pict_pkg::CW-1:0] y_prev,
	input  logic signed [pict_pkg::ZW-1:0] z_prev,
	output logic signed [pict_pkg::CW-1:0] x_next,
	output logic signed [pict_pkg::CW-1:0] y_next,
	output logic signed [pict_pkg::ZW-1:0] z_next
);
	localparam logic signed [pict_pkg::ZW-1:0] ATAN =
		pict_pkg::ZW'(pict_pkg::atan_q30(STEP));

	logic signed [pict_pkg::CW-1:0] dx, dy;
	logic signed [pict_pkg::CW-1:0] x_s1, y_s1;
	logic signed [pict_pkg::ZW-1:0] z_s1;

	assign dx = y_prev >>> STEP;
	assign dy = x_prev >>> STEP;

	// rotate clockwise while y is positive, else counterclockwise
	always_ff @(posedge clk) begin
		if (en) begin
			if (y_prev > 0) begin
				x_s1 <= x_prev + dx;
				y_s1 <= y_prev - dy;
				z_s1 <= z_prev + ATAN;
			end else begin
				x_s1 <= x_prev - dx;
				y_s1 <= y_prev + dy;
				z_s1 <= z_prev - ATAN;
			end
		end
	end

	assign x_next = x_s1;
	assign y_next = y_s1;
	assign z_next = z_s1;

endmodule

// ===== src/pict_cordic.sv =====
// ----------------------------------------------------------------------------
// pict_cordic: pipelined vectoring CORDIC
// One stage per micro-rotation; returns the accumulated angle in Q.30.
// ----------------------------------------------------------------------------
module pict_cordic (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [pict_pkg::CW-1:0] x,
	input  logic signed [pict_pkg::CW-1:0] y,
	input  logic signed [pict_pkg::ZW-1:0] z,
	output logic signed [pict_pkg::ZW-1:0] angle
);
	localparam int N = pict_pkg::CORDIC_STEPS;

	logic signed [pict_pkg::CW-1:0] xc [N+1];
	logic signed [pict_pkg::CW-1:0] yc [N+1];
	logic signed [pict_pkg::ZW-1:0] zc [N+1];

	assign xc[0] = x;
	assign yc[0] = y;
	assign zc[0] = z;

	// chain the micro-rotations
	for (genvar i = 0; i < N; i++) begin : g_step
		pict_cordic_step #(
			.STEP(i)
		) u_step (
			.clk   (clk),
			.en    (en),
			.x_prev(xc[i]),
			.y_prev(yc[i]),
			.z_prev(zc[i]),
			.x_next(xc[i+1]),
			.y_next(yc[i+1]),
			.z_next(zc[i+1])
		);
	end

	// the final x and y are left unused; only the angle is returned
	assign angle = zc[N];

endmodule

// ===== src/point_in_circumcircle_test.sv =====
// ----------------------------------------------------------------------------
// point_in_circumcircle_test: opposite-angle circumcircle test
// Sums the angles at B and D of quadrilateral A-B-C-D and compares with pi.
//
//   channel   dir  payload                                    handshake
//   pts       in   a_x a_y b_x b_y c_x c_y d_x d_y            valid/ready
//   res       out  position angle_sum degenerate              valid/ready
//   tol       in   tol_wdata (angle_tolerance, Q0.13)         tol_we
//
// One test per cycle while res keeps up; res.valid rises once a test has passed
// the input stage, 7 front-end stages, 31 CORDIC stages, rounding and output.
// The 31-step CORDIC sets the depth. Reset clears all valid bits and loads
// the tolerance with its default. A stall on res freezes the whole pipe once
// the skid register holds the next transaction; bubbles keep moving until then.
// ----------------------------------------------------------------------------
module point_in_circumcircle_test #(
	parameter int COORD_WIDTH     = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pict_pts_if.sink                      pts,
	pict_res_if.source                    res,
	input  logic                          tol_we,
	input  logic [pict_pkg::TOL_W-1:0]    tol_wdata
);
	localparam int DW    = COORD_WIDTH + 1;
	localparam int AS    = 30 - ANGLE_FRAC_BITS;
	localparam int AW    = ANGLE_FRAC_BITS + 2;
	localparam int SUMW  = AW + 1;
	localparam int SIDEN = 7 + pict_pkg::CORDIC_STEPS + 1;
	localparam longint PI_Q = (pict_pkg::PI_Q30 + (64'sd1 <<< (AS - 1))) >>> AS;
	localparam logic signed [pict_pkg::ZW-1:0] PI_Z     = pict_pkg::ZW'(pict_pkg::PI_Q30);
	localparam logic [pict_pkg::ZW-1:0]        HALF_LSB = pict_pkg::ZW'(1) << (AS - 1);

	logic en;

	// tolerance register
	logic [pict_pkg::TOL_W-1:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= pict_pkg::TOL_RESET;
		end else if (tol_we) begin
			tol_q <= tol_wdata;
		end
	end

	// s1: side vectors and zero-length check
	logic signed [DW-1:0] bax_s1, bay_s1, bcx_s1, bcy_s1;
	logic signed [DW-1:0] dax_s1, day_s1, dcx_s1, dcy_s1;
	logic                 v_s1, deg_s1;
	logic                 deg;

	assign deg = (pts.a_x == pts.b_x && pts.a_y == pts.b_y) ||
	             (pts.c_x == pts.b_x && pts.c_y == pts.b_y) ||
	             (pts.a_x == pts.d_x && pts.a_y == pts.d_y) ||
	             (pts.c_x == pts.d_x && pts.c_y == pts.d_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			deg_s1 <= 1'b0;
		end else if (en) begin
			v_s1   <= pts.valid;
			deg_s1 <= deg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bax_s1 <= DW'(pts.a_x) - DW'(pts.b_x);
			bay_s1 <= DW'(pts.a_y) - DW'(pts.b_y);
			bcx_s1 <= DW'(pts.c_x) - DW'(pts.b_x);
			bcy_s1 <= DW'(pts.c_y) - DW'(pts.b_y);
			dax_s1 <= DW'(pts.a_x) - DW'(pts.d_x);
			day_s1 <= DW'(pts.a_y) - DW'(pts.d_y);
			dcx_s1 <= DW'(pts.c_x) - DW'(pts.d_x);
			dcy_s1 <= DW'(pts.c_y) - DW'(pts.d_y);
		end
	end

	// valid and degenerate flag travel alongside the datapath
	pict_pkg::side_t side_q [SIDEN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SIDEN; i++) begin
				side_q[i] <= '0;
			end
		end else if (en) begin
			side_q[0] <= '{valid: v_s1, degenerate: deg_s1};
			for (int i = 1; i < SIDEN; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	// angle at B and angle at D
	logic signed [pict_pkg::CW-1:0] bx0, by0, dx0, dy0;
	logic signed [pict_pkg::ZW-1:0] bz0, dz0, bz, dz;

	pict_front #(.DW(DW)) u_front_b (
		.clk(clk), .en(en),
		.ux(bax_s1), .uy(bay_s1), .vx(bcx_s1), .vy(bcy_s1),
		.cx(bx0), .cy(by0), .cz(bz0)
	);

	pict_front #(.DW(DW)) u_front_d (
		.clk(clk), .en(en),
		.ux(dax_s1), .uy(day_s1), .vx(dcx_s1), .vy(dcy_s1),
		.cx(dx0), .cy(dy0), .cz(dz0)
	);

	pict_cordic u_cordic_b (
		.clk(clk), .en(en), .x(bx0), .y(by0), .z(bz0), .angle(bz)
	);

	pict_cordic u_cordic_d (
		.clk(clk), .en(en), .x(dx0), .y(dy0), .z(dz0), .angle(dz)
	);

	// s40: clamp to [0, pi] and round to the output format
	logic [pict_pkg::ZW-1:0] rb, rd;
	logic [AW-1:0]           ang_b_s40, ang_d_s40;

	always_comb begin
		logic signed [pict_pkg::ZW-1:0] cb, cd;
		cb = (bz < 0) ? '0 : ((bz > PI_Z) ? PI_Z : bz);
		cd = (dz < 0) ? '0 : ((dz > PI_Z) ? PI_Z : dz);
		rb = (pict_pkg::ZW'(cb) + HALF_LSB) >> AS;
		rd = (pict_pkg::ZW'(cd) + HALF_LSB) >> AS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_b_s40 <= rb[AW-1:0];
			ang_d_s40 <= rd[AW-1:0];
		end
	end

	// compare the angle sum with pi
	logic [SUMW-1:0]        sum;
	logic signed [SUMW+1:0] diff;
	logic [SUMW+1:0]        dmag;
	pict_pkg::res_t         nres;
	logic                   nvalid;

	assign sum    = SUMW'(ang_b_s40) + SUMW'(ang_d_s40);
	assign diff   = signed'({2'b00, sum}) - signed'((SUMW+2)'(PI_Q));
	assign dmag   = diff[SUMW+1] ? (SUMW+2)'(-diff) : (SUMW+2)'(diff);
	assign nvalid = side_q[SIDEN-1].valid;

	always_comb begin
		logic [31:0] sum32;
		sum32 = 32'(sum);
		if (side_q[SIDEN-1].degenerate) begin
			nres = '{position: pict_pkg::POS_OUTSIDE, angle_sum: '0, degenerate: 1'b1};
		end else begin
			nres.degenerate = 1'b0;
			nres.angle_sum  = sum32[pict_pkg::SUM_OUT_W-1:0];
			if (32'(dmag) < 32'(tol_q)) begin
				nres.position = pict_pkg::POS_ON;
			end else if (diff > 0) begin
				nres.position = pict_pkg::POS_INSIDE;
			end else begin
				nres.position = pict_pkg::POS_OUTSIDE;
			end
		end
	end

	// output register plus skid; the pipe advances while the skid is empty
	pict_pkg::res_t out_q, skid_q;
	logic           out_v_q, skid_v_q;
	logic           take;

	assign en        = !skid_v_q;
	assign take      = out_v_q && res.ready;
	assign pts.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q  <= en && nvalid;
			end
		end else if (en && nvalid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (en && nvalid) begin
				out_q <= nres;
			end
		end else if (en && nvalid) begin
			skid_q <= nres;
		end
	end

	assign res.valid      = out_v_q;
	assign res.position   = out_q.position;
	assign res.angle_sum  = out_q.angle_sum;
	assign res.degenerate = out_q.degenerate;

`ifndef SYNTHESIS
	// skid only fills behind an occupied output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a transaction while output is empty");

	// skid fills only when the output stalled
	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !res.ready))
		else $error("skid filled without an output stall");

	// degenerate results report outside with a zero sum
	a_degenerate_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.degenerate) |->
			(res.position == pict_pkg::POS_OUTSIDE && res.angle_sum == '0))
		else $error("degenerate result with wrong position or sum");
`endif

endmodule

// ===== test/tb_point_in_circumcircle_test.sv =====
// ----------------------------------------------------------------------------
// tb_point_in_circumcircle_test: self-checking bench of the circumcircle test
// Drives point sets through the valid/ready channel, predicts each result with
// a bit-exact CORDIC angle model and compares it with the block output. Both
// sides idle at random; the bench covers a long result stall and a drain.
// ----------------------------------------------------------------------------
module tb_point_in_circumcircle_test;

	localparam int CWID      = 16;
	localparam int ANG_SHIFT = 30 - 13;
	localparam int LATENCY   = 41;
	localparam longint unsigned NORM_HI = 64'h0400_0000_0000_0000;
	localparam longint unsigned NORM_LO = 64'h0200_0000_0000_0000;

	// atan(2^-i) in Q.30, truncated; entries 27 to 30 are rounded up
	localparam longint ATAN_TBL [pict_pkg::CORDIC_STEPS] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
		64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
		64'h00000001
	};

	typedef struct packed {
		logic signed [CWID-1:0] ax, ay, bx, by, cx, cy, dx, dy;
	} quad_t;

	logic clk;
	logic arst_n;
	logic tol_we;
	logic [pict_pkg::TOL_W-1:0] tol_wdata;

	pict_pts_if #(.COORD_WIDTH(CWID)) pts_bus ();
	pict_res_if res_bus ();

	point_in_circumcircle_test #(.COORD_WIDTH(CWID), .ANGLE_FRAC_BITS(13)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pts       (pts_bus),
		.res       (res_bus),
		.tol_we    (tol_we),
		.tol_wdata (tol_wdata)
	);

	pict_pkg::res_t             verdict_q [$];
	logic [pict_pkg::TOL_W-1:0] tol_cur;
	int                         errors;
	bit                         no_idle;
	bit                         hold_req;
	int                         hold_left;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_point_in_circumcircle_test: errors");
		$finish;
	end

	// clamp to [0, pi] and round half up to Q2.13
	function automatic longint round_q13(longint a);
		if (a < 0) a = 0;
		if (a > pict_pkg::PI_Q30) a = pict_pkg::PI_Q30;
		return (a + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
	endfunction

	// angle between two nonzero vectors by vectoring CORDIC on (dot, |cross|)
	function automatic longint vec_angle_q13(longint ux, longint uy, longint vx, longint vy);
		longint dot, crs, x, y, z, sx, sy;
		longint unsigned px, py;
		dot = ux * vx + uy * vy;
		crs = ux * vy - uy * vx;
		if (crs < 0) crs = -crs;
		if (dot < 0) begin
			px = crs; py = -dot; z = pict_pkg::HALF_PI_Q30;
		end else begin
			px = dot; py = crs; z = 0;
		end
		if (px == 0 && py == 0) return round_q13(z);
		while ((px | py) >= NORM_HI) begin
			px = px >> 1; py = py >> 1;
		end
		while ((px | py) < NORM_LO) begin
			px = px << 1; py = py << 1;
		end
		x = px;
		y = py;
		for (int i = 0; i < pict_pkg::CORDIC_STEPS; i++) begin
			sx = y >>> i;
			sy = x >>> i;
			if (y > 0) begin
				x += sx; y -= sy; z += ATAN_TBL[i];
			end else begin
				x -= sx; y += sy; z -= ATAN_TBL[i];
			end
		end
		return round_q13(z);
	endfunction

	function automatic pict_pkg::res_t classify_quad(quad_t q, logic [pict_pkg::TOL_W-1:0] tol);
		pict_pkg::res_t r;
		longint bax, bay, bcx, bcy, dax, day, dcx, dcy, sum, diff;
		bax = q.ax - q.bx; bay = q.ay - q.by; bcx = q.cx - q.bx; bcy = q.cy - q.by;
		dax = q.ax - q.dx; day = q.ay - q.dy; dcx = q.cx - q.dx; dcy = q.cy - q.dy;
		if ((bax == 0 && bay == 0) || (bcx == 0 && bcy == 0) ||
		    (dax == 0 && day == 0) || (dcx == 0 && dcy == 0)) begin
			r.position = pict_pkg::POS_OUTSIDE; r.angle_sum = '0; r.degenerate = 1'b1;
			return r;
		end
		sum  = vec_angle_q13(bax, bay, bcx, bcy) + vec_angle_q13(dax, day, dcx, dcy);
		diff = sum - round_q13(pict_pkg::PI_Q30);
		if ((diff < 0 ? -diff : diff) < longint'(tol)) r.position = pict_pkg::POS_ON;
		else if (diff > 0) r.position = pict_pkg::POS_INSIDE;
		else r.position = pict_pkg::POS_OUTSIDE;
		r.angle_sum  = sum[15:0];
		r.degenerate = 1'b0;
		return r;
	endfunction

	// result side: random ready, with a counted hold-off on request
	initial begin
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = 300;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				res_bus.ready <= 1'b0;
				hold_left--;
			end else if (no_idle) begin
				res_bus.ready <= 1'b1;
			end else begin
				res_bus.ready <= ($urandom_range(99) >= 32);
			end
		end
	end

	// compare each result transaction with the oldest prediction
	initial begin
		pict_pkg::res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_bus.valid && res_bus.ready) begin
				if (verdict_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result transaction");
				end else begin
					want = verdict_q.pop_front();
					if (res_bus.position !== want.position ||
					    res_bus.angle_sum !== want.angle_sum ||
					    res_bus.degenerate !== want.degenerate) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp pos %0d sum %0d deg %0d, got pos %0d sum %0d deg %0d",
								want.position, want.angle_sum, want.degenerate,
								res_bus.position, res_bus.angle_sum, res_bus.degenerate);
					end
				end
			end
		end
	end

	// offer one transaction; valid stays high afterward until the next call or a drain
	task automatic send_quad(quad_t q);
		if (!no_idle) begin
			while ($urandom_range(99) < 32) begin
				pts_bus.valid <= 1'b0;
				@(negedge clk);
			end
		end
		{pts_bus.a_x, pts_bus.a_y, pts_bus.b_x, pts_bus.b_y,
		 pts_bus.c_x, pts_bus.c_y, pts_bus.d_x, pts_bus.d_y} <= q;
		pts_bus.valid <= 1'b1;
		do @(posedge clk); while (!pts_bus.ready);
		verdict_q.push_back(classify_quad(q, tol_cur));
		@(negedge clk);
	endtask

	task automatic drain_results();
		pts_bus.valid <= 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	task automatic write_tolerance(logic [pict_pkg::TOL_W-1:0] v);
		drain_results();
		tol_we    <= 1'b1;
		tol_wdata <= v;
		tol_cur    = v;
		@(negedge clk);
		tol_we <= 1'b0;
	endtask

	function automatic logic signed [CWID-1:0] rnd_coord();
		return CWID'($urandom);
	endfunction

	// rectangle corners in order: opposite angles are both right angles
	function automatic quad_t rect_quad(int mx, int my, int hw, int hh);
		quad_t q;
		q.ax = CWID'(mx - hw); q.ay = CWID'(my - hh);
		q.bx = CWID'(mx + hw); q.by = CWID'(my - hh);
		q.cx = CWID'(mx + hw); q.cy = CWID'(my + hh);
		q.dx = CWID'(mx - hw); q.dy = CWID'(my + hh);
		return q;
	endfunction

	function automatic quad_t random_quad();
		quad_t q;
		int    kind, mx, my;
		kind = $urandom_range(99);
		if (kind < 40) begin
			q = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
			     rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
		end else if (kind < 85) begin
			mx = $urandom_range(32000) - 16000;
			my = $urandom_range(32000) - 16000;
			q  = rect_quad(mx, my, $urandom_range(16000, 1), $urandom_range(16000, 1));
			if (kind >= 70) begin
				// nudge D a little off the circle
				q.dx = CWID'(int'(q.dx) + int'($urandom_range(8)) - 4);
				q.dy = CWID'(int'(q.dy) + int'($urandom_range(8)) - 4);
			end
		end else begin
			// tiny coordinates: coincident points are common
			q.ax = CWID'($urandom_range(2)); q.ay = CWID'($urandom_range(2));
			q.bx = CWID'($urandom_range(2)); q.by = CWID'($urandom_range(2));
			q.cx = CWID'($urandom_range(2)); q.cy = CWID'($urandom_range(2));
			q.dx = CWID'($urandom_range(2)); q.dy = CWID'($urandom_range(2));
		end
		return q;
	endfunction

	task automatic test_directed();
		localparam logic signed [CWID-1:0] MX = 16'sh7FFF, MN = -16'sh8000;
		send_quad(rect_quad(0, 0, 100, 100));
		send_quad(rect_quad(0, 0, 16383, 16383));
		send_quad('{ax: MN, ay: MN, bx: MX, by: MN, cx: MX, cy: MX, dx: MN, dy: MX});
		send_quad('{ax: MX, ay: MX, bx: MN, by: MX, cx: MN, cy: MN, dx: MX, dy: MN});
		// D at the center: inside
		send_quad('{ax: -100, ay: 0, bx: 0, by: -100, cx: 100, cy: 0, dx: 0, dy: 0});
		// D far away: outside
		send_quad('{ax: -100, ay: 0, bx: 0, by: -100, cx: 100, cy: 0, dx: 0, dy: 30000});
		// each side of zero length
		send_quad('{ax: 5, ay: 5, bx: 5, by: 5, cx: 9, cy: 1, dx: -3, dy: 7});
		send_quad('{ax: 5, ay: 5, bx: 9, by: 1, cx: 9, cy: 1, dx: -3, dy: 7});
		send_quad('{ax: 5, ay: 5, bx: 9, by: 1, cx: -2, cy: 4, dx: 5, dy: 5});
		send_quad('{ax: 5, ay: 5, bx: 9, by: 1, cx: -2, cy: 4, dx: -2, dy: 4});
		send_quad('{default: 0});
		// collinear: straight angle at B, zero angle at D
		send_quad('{ax: -10, ay: 0, bx: 0, by: 0, cx: 10, cy: 0, dx: 20, dy: 0});
		// A equals C: both angles zero
		send_quad('{ax: 7, ay: 3, bx: 0, by: 0, cx: 7, cy: 3, dx: -4, dy: 9});
		// full-range coordinates; the first has a straight angle at B, a nearly straight one at D
		send_quad('{ax: MN, ay: 0, bx: 0, by: 0, cx: MX, cy: 0, dx: 0, dy: 1});
		send_quad('{ax: MN, ay: MN, bx: MX, by: MX, cx: MX, cy: MN, dx: MN, dy: MX});
		send_quad('{ax: MX, ay: MN, bx: MN, by: MX, cx: 1, cy: -1, dx: -1, dy: 1});
		drain_results();
	endtask

	task automatic test_tolerance_sweep();
		logic [pict_pkg::TOL_W-1:0] levels [4];
		levels = '{13'd0, 13'd8191, 13'd1, pict_pkg::TOL_RESET};
		foreach (levels[k]) begin
			write_tolerance(levels[k]);
			repeat (40) send_quad(random_quad());
		end
		write_tolerance(pict_pkg::TOL_W'($urandom_range(8191)));
		repeat (40) send_quad(random_quad());
		write_tolerance(13'd82);
	endtask

	task automatic test_random_stream();
		repeat (400) send_quad(random_quad());
		// stretch with no idling on either side
		no_idle = 1'b1;
		repeat (150) send_quad(random_quad());
		no_idle = 1'b0;
	endtask

	task automatic test_result_stall();
		hold_req = 1'b1;
		repeat (100) send_quad(random_quad());
	endtask

	task automatic test_sender_pause();
		drain_results();
		repeat (30) send_quad(random_quad());
		drain_results();
	endtask

	initial begin
		errors         = 0;
		no_idle        = 1'b0;
		hold_req       = 1'b0;
		tol_cur        = pict_pkg::TOL_RESET;
		arst_n         = 1'b0;
		tol_we         = 1'b0;
		tol_wdata      = '0;
		pts_bus.valid  = 1'b0;
		{pts_bus.a_x, pts_bus.a_y, pts_bus.b_x, pts_bus.b_y,
		 pts_bus.c_x, pts_bus.c_y, pts_bus.d_x, pts_bus.d_y} = '0;
		res_bus.ready  = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_tolerance_sweep();
		test_random_stream();
		test_result_stall();
		test_sender_pause();

		drain_results();
		if (errors == 0 && verdict_q.size() == 0) begin
			$display("tb_point_in_circumcircle_test: clean");
		end else begin
			$display("tb_point_in_circumcircle_test: errors");
		end
		$finish;
	end
endmodule

// ===== point_in_circumcircle_test.f =====
src/pict_pkg.sv
src/pict_pts_if.sv
src/pict_res_if.sv
src/pict_front.sv
src/pict_cordic_step.sv
src/pict_cordic.sv
src/point_in_circumcircle_test.sv
test/tb_point_in_circumcircle_test.sv
